[rtl/lpm_pkg.sv]
// Shared types and constants for the longest-prefix-match route lookup.
// Used by lpm_cell and longest_prefix_match_lookup; depends on nothing else.
package lpm_pkg;

   localparam int unsigned LPM_ENTRIES = 16;
   localparam int unsigned IDX_BITS    = 4;
   localparam int unsigned ADDR_BITS   = 32;

   typedef enum logic {
      REQ_WRITE  = 1'b0,
      REQ_LOOKUP = 1'b1
   } req_kind_type;

   typedef struct packed {
      logic                  valid;
      req_kind_type          kind;
      logic [IDX_BITS-1:0]   entry_index;
      logic [ADDR_BITS-1:0]  entry_dest;
      logic [ADDR_BITS-1:0]  entry_mask;
      logic                  entry_valid;
      logic [ADDR_BITS-1:0]  addr;
      logic                  found;
      logic [IDX_BITS-1:0]   best_idx;
      logic [ADDR_BITS-1:0]  best_mask;
   } lpm_token_type;

endpackage

[rtl/longest_prefix_match_lookup.sv]
// Longest-prefix-match IPv4 route lookup: top level with the cell chain and result register.
// Depends on lpm_pkg and lpm_cell.
//
// Every transfer, write or lookup, enters a chain of ENTRIES cells, one route slot per cell,
// and moves one cell per cycle while the chain advances, so each cell sees items in arrival
// order. A lookup gathers the best match as it passes; a write updates its own slot on the way.
// The result passes through every cell register and then the result register, and a new item
// can be taken every cycle unless the result is stalled. A stalled result stops the whole chain.
module longest_prefix_match_lookup #(
   parameter int unsigned ENTRIES = lpm_pkg::LPM_ENTRIES
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_ready,
   input  logic                            req_type,
   input  logic [lpm_pkg::IDX_BITS-1:0]    req_entry_index,
   input  logic [lpm_pkg::ADDR_BITS-1:0]   req_entry_dest,
   input  logic [lpm_pkg::ADDR_BITS-1:0]   req_entry_mask,
   input  logic                            req_entry_valid,
   input  logic [lpm_pkg::ADDR_BITS-1:0]   req_lookup_addr,
   output logic                            rsp_valid,
   input  logic                            rsp_ready,
   output logic                            rsp_hit,
   output logic [lpm_pkg::IDX_BITS-1:0]    rsp_match_index,
   output logic [lpm_pkg::ADDR_BITS-1:0]   rsp_match_mask
);
   import lpm_pkg::*;

   lpm_token_type        tok [ENTRIES+1];
   logic                 advance;
   logic                 rsp_valid_ff;
   logic                 rsp_hit_ff;
   logic [IDX_BITS-1:0]  rsp_index_ff;
   logic [ADDR_BITS-1:0] rsp_mask_ff;

   assign advance   = !rsp_valid_ff || rsp_ready;
   assign req_ready = advance;

   assign tok[0] = '{
      valid:       req_valid,
      kind:        req_kind_type'(req_type),
      entry_index: req_entry_index,
      entry_dest:  req_entry_dest,
      entry_mask:  req_entry_mask,
      entry_valid: req_entry_valid,
      addr:        req_lookup_addr,
      found:       1'b0,
      best_idx:    '0,
      best_mask:   '0
   };

   for (genvar i = 0; i < ENTRIES; i++) begin : g_cell
      lpm_cell #(
         .CELL_ID(i)
      ) u_cell (
         .clock  (clock),
         .reset  (reset),
         .advance(advance),
         .tok_i  (tok[i]),
         .tok_o  (tok[i+1])
      );
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= tok[ENTRIES].valid;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_hit_ff   <= tok[ENTRIES].found;
         rsp_index_ff <= tok[ENTRIES].best_idx;
         rsp_mask_ff  <= tok[ENTRIES].best_mask;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_hit         = rsp_hit_ff;
   assign rsp_match_index = rsp_index_ff;
   assign rsp_match_mask  = rsp_mask_ff;

`ifndef SYNTHESIS
   a_miss_output_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_hit |-> (rsp_match_index == '0) && (rsp_match_mask == '0))
      else $error("result without a hit carries a nonzero route");

   a_chain_empty_after_reset: assert property (@(posedge clock)
      reset |=> !rsp_valid_ff && !tok[ENTRIES].valid)
      else $error("chain holds a token right after reset");

   a_result_loaded_from_chain: assert property (@(posedge clock) disable iff (reset)
      advance && tok[ENTRIES].valid |=> rsp_valid_ff)
      else $error("token left the chain without reaching the result register");
`endif

endmodule

[rtl/lpm_cell.sv]
// One route slot of the lookup chain: holds a route and updates the passing token.
// Depends on lpm_pkg.
module lpm_cell #(
   parameter int unsigned CELL_ID = 0
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  advance,
   input  lpm_pkg::lpm_token_type tok_i,
   output lpm_pkg::lpm_token_type tok_o
);
   import lpm_pkg::*;

   localparam logic [31:0] ID = 32'(CELL_ID);

   logic [ADDR_BITS-1:0] dest_ff;
   logic [ADDR_BITS-1:0] mask_ff;
   logic                 valid_ff;
   lpm_token_type        tok_ff;
   lpm_token_type        tok_in;
   logic                 hit_here;
   logic                 write_here;

   assign write_here = advance && tok_i.valid && (tok_i.kind == REQ_WRITE)
                       && (32'(tok_i.entry_index) == ID);

   assign hit_here = valid_ff && tok_i.valid && (tok_i.kind == REQ_LOOKUP)
                     && ((tok_i.addr & mask_ff) == (dest_ff & mask_ff));

   always_comb begin
      tok_in = tok_i;
      if (hit_here && (!tok_i.found || (mask_ff > tok_i.best_mask))) begin
         tok_in.found     = 1'b1;
         tok_in.best_idx  = IDX_BITS'(CELL_ID);
         tok_in.best_mask = mask_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (write_here) begin
         valid_ff <= tok_i.entry_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (write_here) begin
         dest_ff <= tok_i.entry_dest;
         mask_ff <= tok_i.entry_mask;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tok_ff.valid <= 1'b0;
      end else if (advance) begin
         tok_ff <= tok_in;
      end
   end

   assign tok_o = tok_ff;

`ifndef SYNTHESIS
   a_write_never_hits: assert property (@(posedge clock) disable iff (reset)
      tok_ff.valid && (tok_ff.kind == REQ_WRITE) |-> !tok_ff.found)
      else $error("write token carries a route hit");

   a_miss_is_zero: assert property (@(posedge clock) disable iff (reset)
      tok_ff.valid && !tok_ff.found |-> (tok_ff.best_idx == '0) && (tok_ff.best_mask == '0))
      else $error("token without a hit carries a nonzero best route");

   a_stall_holds: assert property (@(posedge clock) disable iff (reset)
      tok_ff.valid && !advance |=> $stable(tok_ff))
      else $error("token changed while the chain was stalled");
`endif

endmodule
